>>> rtl/vtpd_pkg.sv
// ----------------------------------------------------------------------------
// vtpd_pkg
// Shared item types and hash constants for the pair dedup indexer.
// ----------------------------------------------------------------------------
package vtpd_pkg;

  typedef struct packed {
    logic        first_of_mesh;
    logic [15:0] vertex_index;
    logic [15:0] texcoord_index;
  } in_item_t;

  typedef struct packed {
    logic [11:0] shared_index;
    logic        is_new;
    logic [15:0] src_vertex;
    logic [15:0] src_texcoord;
    logic        overflow;
  } out_item_t;

  localparam logic [31:0] HASH_MUL_V = 32'd218943212;
  localparam logic [31:0] HASH_MUL_T = 32'd168875421;

  // width of the per-slot mesh generation mark
  localparam int EPOCH_BITS = 4;

endpackage

>>> rtl/vtpd_queue.sv
// ----------------------------------------------------------------------------
// vtpd_queue
// Two-entry queue between the hashing front and the table back end.
// ----------------------------------------------------------------------------
module vtpd_queue #(
  parameter int W = 45
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         not_empty,
  output logic [W-1:0] pop_data
);

  logic [W-1:0] slot_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;
  logic         do_push, do_pop;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign pop_data  = slot_r[rp_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= push_data;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) begin
        wp_r <= ~wp_r;
      end
      if (do_pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

>>> rtl/vtpd_front.sv
// ----------------------------------------------------------------------------
// vtpd_front
// Accepts corners, registers the hash products and forms the hashed home
// slot from them, then pushes the job into the queue.
// ----------------------------------------------------------------------------
module vtpd_front import vtpd_pkg::*; #(
  parameter int MAX_ENTRIES    = 4096,
  parameter int SRC_INDEX_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  in_item_t                              in_item,
  input  logic                                  q_full,
  output logic                                  q_push,
  output logic [33+$clog2(MAX_ENTRIES)-1:0]     q_data
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int SB = SRC_INDEX_BITS;
  localparam int HB = AW + 17;

  in_item_t        s1_item_r;
  logic            s1_v_r;
  logic [HB-1:0]   pv_r, pt_r;
  logic [SB+15:0]  vx, tx;
  logic [31:0]     kv32, kt32;
  logic [63:0]     pv_full, pt_full;
  logic [HB-1:0]   h, hx;

  // keys are the low SRC_INDEX_BITS of each source index
  assign vx      = {{SB{1'b0}}, in_item.vertex_index};
  assign tx      = {{SB{1'b0}}, in_item.texcoord_index};
  assign kv32    = 32'(vx[SB-1:0]);
  assign kt32    = 32'(tx[SB-1:0]);
  assign pv_full = kv32 * HASH_MUL_V;
  assign pt_full = kt32 * HASH_MUL_T;

  assign h  = pv_r + pt_r;
  assign hx = h ^ (h >> 17);

  assign in_ready = !s1_v_r || !q_full;
  assign q_push   = s1_v_r;
  assign q_data   = {s1_item_r.first_of_mesh, s1_item_r.vertex_index,
                     s1_item_r.texcoord_index, hx[AW-1:0]};

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_item;
      pv_r      <= pv_full[HB-1:0];
      pt_r      <= pt_full[HB-1:0];
    end
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ready) begin
      s1_v_r <= in_valid;
    end
  end

endmodule

>>> rtl/vtpd_back.sv
// ----------------------------------------------------------------------------
// vtpd_back
// Pair table: linear probe over a slot memory with one read and one write
// port, insert on miss, generation-marked clearing, and the result register.
// ----------------------------------------------------------------------------
module vtpd_back import vtpd_pkg::*; #(
  parameter int MAX_ENTRIES    = 4096,
  parameter int SRC_INDEX_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_not_empty,
  input  logic [33+$clog2(MAX_ENTRIES)-1:0]  q_data,
  output logic                               q_pop,
  output logic                               out_valid,
  input  logic                               out_ready,
  output out_item_t                          out_item
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int SB = SRC_INDEX_BITS;
  localparam int KW = 2 * SB;
  localparam int EW = EPOCH_BITS;
  localparam int MW = 1 + EW + KW + AW;

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_READ, S_CHECK, S_OUT
  } state_t;

  state_t          state_r;
  logic [MW-1:0]   mem [MAX_ENTRIES];
  logic [MW-1:0]   rd_r;
  logic [AW-1:0]   slot_r, clr_r;
  logic [AW:0]     probes_r, count_r;
  logic [EW-1:0]   epoch_r, epoch_inc;
  logic            pend_r;
  logic [KW-1:0]   key_r;
  logic [15:0]     jv_r, jt_r;
  logic [AW-1:0]   res_idx_r;
  logic            res_new_r, res_ovf_r;
  out_item_t       out_r;
  logic            out_valid_r;

  logic            j_first;
  logic [15:0]     j_v, j_t;
  logic [AW-1:0]   j_home;
  logic [SB+15:0]  vx, tx;
  logic            we;
  logic [AW-1:0]   wa;
  logic [MW-1:0]   wd;
  logic            rd_vb, rd_live, rd_match;
  logic [EW-1:0]   rd_ep;
  logic [KW-1:0]   rd_key;
  logic [AW-1:0]   rd_idx;
  logic [AW+11:0]  idx_ext;
  logic            out_load;

  assign {j_first, j_v, j_t, j_home} = q_data;
  assign vx = {{SB{1'b0}}, j_v};
  assign tx = {{SB{1'b0}}, j_t};
  assign epoch_inc = epoch_r + 1'b1;

  assign {rd_vb, rd_ep, rd_key, rd_idx} = rd_r;
  assign rd_live  = rd_vb && (rd_ep == epoch_r);
  assign rd_match = (rd_key == key_r);

  assign q_pop = (state_r == S_IDLE) && q_not_empty;

  assign we = (state_r == S_CLR) || ((state_r == S_CHECK) && !rd_live);
  assign wa = (state_r == S_CLR) ? clr_r : slot_r;
  assign wd = (state_r == S_CLR) ? '0 : {1'b1, epoch_r, key_r, count_r[AW-1:0]};

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_r <= mem[slot_r];
  end

  assign idx_ext   = {12'b0, res_idx_r};
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r.shared_index <= idx_ext[11:0];
      out_r.is_new       <= res_new_r;
      out_r.src_vertex   <= jv_r;
      out_r.src_texcoord <= jt_r;
      out_r.overflow     <= res_ovf_r;
    end
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      pend_r      <= 1'b0;
      epoch_r     <= '0;
      count_r     <= '0;
      probes_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == AW'(MAX_ENTRIES - 1)) begin
            pend_r  <= 1'b0;
            state_r <= pend_r ? S_READ : S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_not_empty) begin
            jv_r     <= j_v;
            jt_r     <= j_t;
            key_r    <= {vx[SB-1:0], tx[SB-1:0]};
            slot_r   <= j_home;
            probes_r <= '0;
            state_r  <= S_READ;
            if (j_first) begin
              // new mesh: bump the generation; a wrap needs a real sweep
              count_r <= '0;
              epoch_r <= epoch_inc;
              if (epoch_inc == '0) begin
                clr_r   <= '0;
                pend_r  <= 1'b1;
                state_r <= S_CLR;
              end
            end
          end
        end
        S_READ: begin
          state_r <= S_CHECK;
        end
        S_CHECK: begin
          if (!rd_live) begin
            res_idx_r <= count_r[AW-1:0];
            res_new_r <= 1'b1;
            res_ovf_r <= 1'b0;
            count_r   <= count_r + 1'b1;
            state_r   <= S_OUT;
          end else if (rd_match) begin
            res_idx_r <= rd_idx;
            res_new_r <= 1'b0;
            res_ovf_r <= 1'b0;
            state_r   <= S_OUT;
          end else if (probes_r == (AW+1)'(MAX_ENTRIES - 1)) begin
            res_idx_r <= '0;
            res_new_r <= 1'b0;
            res_ovf_r <= 1'b1;
            state_r   <= S_OUT;
          end else begin
            slot_r   <= slot_r + 1'b1;
            probes_r <= probes_r + 1'b1;
            state_r  <= S_READ;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/vertex_tc_pair_dedup_indexer_unit.sv
// ----------------------------------------------------------------------------
// vertex_tc_pair_dedup_indexer_unit
// Maps (vertex, texcoord) corner pairs to dense indices in order of first use.
// ----------------------------------------------------------------------------
// Each accepted item is a face corner; one result item comes back per corner,
// in order. A front stage hashes the pair into a home slot (one multiply
// stage, one add/xor stage) and parks it in a two-entry queue, so corners keep
// flowing in while the back end works. The back end probes a slot memory
// with one read and one write port linearly: it pops a job, reads and then
// compares each slot visited, and loads the result register, taking the next
// job only once that register has taken the result. MAX_ENTRIES must be a
// power of two. Mesh starts are handled by a 4-bit generation mark per slot,
// so they cost nothing, except that every sixteenth mesh start and the time
// straight after reset run a clearing sweep over all MAX_ENTRIES slots (4096
// by default) during which no corner is processed. Overflowed corners return
// index 0 with the overflow flag set; the source indices are always echoed.
module vertex_tc_pair_dedup_indexer_unit import vtpd_pkg::*; #(
  parameter int MAX_ENTRIES    = 4096,
  parameter int SRC_INDEX_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int JW = 33 + AW;

  logic          q_full, q_push, q_pop, q_not_empty;
  logic [JW-1:0] q_in, q_out;

  vtpd_front #(
    .MAX_ENTRIES    (MAX_ENTRIES),
    .SRC_INDEX_BITS (SRC_INDEX_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  vtpd_queue #(
    .W (JW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_out)
  );

  vtpd_back #(
    .MAX_ENTRIES    (MAX_ENTRIES),
    .SRC_INDEX_BITS (SRC_INDEX_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_data      (q_out),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item)
  );

endmodule
